>>> rtl/uesd_pkg.sv
// ----------------------------------------------------------------------------
// uesd_pkg: ultrasonic echo stop detector package
// field widths, conversion constants, register indexes, decision codes and
// sequencer states
// ----------------------------------------------------------------------------
package uesd_pkg;

	localparam int DUR_W      = 16;
	localparam int DIST_W     = 17;
	localparam int CFG_W      = 16;
	localparam int AVG_W      = 16;
	localparam int VS_W       = 3;
	localparam int DEC_W      = 2;
	localparam int MUL_W      = 11;
	localparam int PROD_W     = DUR_W + MUL_W;
	localparam int DIST_SHIFT = 10;

	localparam logic [MUL_W-1:0] DIST_MUL = MUL_W'(1756);

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_STOP_DIST = 2'd0,
		REG_MIN_DIST  = 2'd1,
		REG_MAX_DIST  = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef enum logic [DEC_W-1:0] {
		DEC_MOVING  = 2'd0,
		DEC_AT_ZONE = 2'd1,
		DEC_NO_READ = 2'd2
	} decision_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_MIN,
		S_MAX,
		S_PREP,
		S_DIV,
		S_CMP,
		S_OUT
	} state_t;

	localparam logic [CFG_W-1:0] STOP_DIST_RST = CFG_W'(1000);
	localparam logic [CFG_W-1:0] MIN_DIST_RST  = CFG_W'(200);
	localparam logic [CFG_W-1:0] MAX_DIST_RST  = CFG_W'(20000);

endpackage

>>> rtl/ultrasonic_echo_stop_detector.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_stop_detector: echo width to distance, windowing and averaging
// turns echo pulse widths into distances, averages a group of them and emits a
// stop or moving decision per group
// ----------------------------------------------------------------------------
// usage
//  - slave stream carries one echo width (microseconds, 0 = no echo) per request
//  - master stream carries one decision per group of SAMPLES_PER_READING requests
//  - apb port holds stop distance, minimum and maximum valid distance
//  - a request passes through accept, multiply, lower and upper window check;
//    the request that closes a group adds the divide set-up, the restoring
//    divide, the stop compare and the result load; a group with no accepted
//    sample skips the divide and the compare
//  - all checks and the divide share one subtractor, one step per cycle
//  - a result sits in an output register; the next request is taken meanwhile,
//    and the sequencer waits at the result load only if that register is full
//  - an at-zone decision latches: later requests are taken and dropped
//  - reset clears the group, the latch and restores the register defaults
// ----------------------------------------------------------------------------
module ultrasonic_echo_stop_detector #(
	parameter int SAMPLES_PER_READING = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [uesd_pkg::DUR_W-1:0]    s_tdata,   // [15:0] echo_duration
	// master stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // [1:0] decision,
	                                                 // [17:2] average_distance,
	                                                 // [20:18] valid_samples
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [uesd_pkg::ADDR_W-1:0]   paddr,
	input  logic [uesd_pkg::DATA_W-1:0]   pwdata,
	output logic [uesd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import uesd_pkg::*;

	// count of samples in a group, sum of up to that many 16-bit distances
	localparam int CNT_W  = $clog2(SAMPLES_PER_READING + 1);
	localparam int SUM_W  = AVG_W + CNT_W;
	localparam int ALU_W  = SUM_W + 1;
	localparam int STEP_W = $clog2(SUM_W);

	localparam logic [CNT_W-1:0]  LAST_IDX  = CNT_W'(SAMPLES_PER_READING - 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	// configuration registers
	logic [CFG_W-1:0] stop_dist_q;
	logic [CFG_W-1:0] min_dist_q;
	logic [CFG_W-1:0] max_dist_q;

	// sequencer and working registers
	state_t            state_q, state_d;
	logic [DUR_W-1:0]  dur_q;
	logic              dur_zero_q;
	logic [DIST_W-1:0] dist_q;
	logic              below_min_q;
	logic [CNT_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              latched_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	decision_t         dec_q;

	// output register
	logic              out_valid_q;
	logic [DEC_W-1:0]  out_dec_q;
	logic [AVG_W-1:0]  out_avg_q;
	logic [VS_W-1:0]   out_vs_q;

	// shared subtractor
	logic [ALU_W-1:0]  alu_a, alu_b, alu_diff;
	logic              alu_borrow;

	logic              in_req, out_free, cfg_wr, sample_ok;
	logic [PROD_W-1:0] prod;
	logic [CNT_W:0]    rem_shift;
	logic [31:0]       cnt_ext;
	logic [VS_W-1:0]   cnt_sat;

	assign in_req   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	assign prod      = PROD_W'(dur_q) * PROD_W'(DIST_MUL);
	assign rem_shift = {rem_q, quo_q[SUM_W-1]};
	assign alu_diff  = alu_a - alu_b;
	assign alu_borrow = alu_diff[ALU_W-1];

	// sample passes when an echo was seen and both window checks pass
	assign sample_ok = !dur_zero_q && !below_min_q && !alu_borrow;

	assign cnt_ext = 32'(cnt_q);
	assign cnt_sat = (cnt_ext > 32'd7) ? VS_W'(7) : cnt_ext[VS_W-1:0];

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_dist_q <= STOP_DIST_RST;
			min_dist_q  <= MIN_DIST_RST;
			max_dist_q  <= MAX_DIST_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_STOP_DIST: stop_dist_q <= pwdata[CFG_W-1:0];
				REG_MIN_DIST:  min_dist_q  <= pwdata[CFG_W-1:0];
				REG_MAX_DIST:  max_dist_q  <= pwdata[CFG_W-1:0];
				REG_NONE:      ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_STOP_DIST: prdata = DATA_W'(stop_dist_q);
			REG_MIN_DIST:  prdata = DATA_W'(min_dist_q);
			REG_MAX_DIST:  prdata = DATA_W'(max_dist_q);
			REG_NONE:      prdata = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_req && !latched_q) state_d = S_MUL;
			S_MUL:  state_d = S_MIN;
			S_MIN:  state_d = S_MAX;
			S_MAX:  state_d = (idx_q == LAST_IDX) ? S_PREP : S_IDLE;
			S_PREP: state_d = (cnt_q == '0) ? S_OUT : S_DIV;
			S_DIV:  if (step_q == LAST_STEP) state_d = S_CMP;
			S_CMP:  state_d = S_OUT;
			S_OUT:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: ready and subtractor operands
	always_comb begin
		s_tready = 1'b0;
		alu_a    = '0;
		alu_b    = '0;
		unique case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_MIN: begin
				// borrow when distance is below the window
				alu_a = ALU_W'(dist_q);
				alu_b = ALU_W'(min_dist_q);
			end
			S_MAX: begin
				// borrow when distance is above the window
				alu_a = ALU_W'(max_dist_q);
				alu_b = ALU_W'(dist_q);
			end
			S_DIV: begin
				alu_a = ALU_W'(rem_shift);
				alu_b = ALU_W'(cnt_q);
			end
			S_CMP: begin
				// borrow when average is beyond the stop distance
				alu_a = ALU_W'(stop_dist_q);
				alu_b = ALU_W'(quo_q[AVG_W-1:0]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			latched_q <= 1'b0;
			step_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_MAX: begin
					idx_q <= idx_q + CNT_W'(1);
					if (sample_ok) begin
						sum_q <= sum_q + SUM_W'(dist_q);
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_PREP: step_q <= '0;
				S_DIV:  step_q <= step_q + STEP_W'(1);
				S_OUT: begin
					if (out_free) begin
						idx_q <= '0;
						sum_q <= '0;
						cnt_q <= '0;
						if (dec_q == DEC_AT_ZONE) latched_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				dur_q      <= s_tdata;
				dur_zero_q <= (s_tdata == '0);
			end
			S_MUL: dist_q <= prod[DIST_SHIFT +: DIST_W];
			S_MIN: below_min_q <= alu_borrow;
			S_PREP: begin
				quo_q <= sum_q;
				rem_q <= '0;
				dec_q <= DEC_NO_READ;
			end
			S_DIV: begin
				// restoring divide, one quotient bit per step
				quo_q <= {quo_q[SUM_W-2:0], !alu_borrow};
				rem_q <= alu_borrow ? rem_shift[CNT_W-1:0] : alu_diff[CNT_W-1:0];
			end
			S_CMP: dec_q <= alu_borrow ? DEC_MOVING : DEC_AT_ZONE;
			default: ;
		endcase
	end

	// output register, loaded when free or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_dec_q <= dec_q;
			// no accepted sample shows a zero average
			out_avg_q <= (dec_q == DEC_NO_READ) ? '0 : quo_q[AVG_W-1:0];
			out_vs_q  <= cnt_sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_vs_q, out_avg_q, out_dec_q};

endmodule
